// File: design/ssms_pkg.sv
// shared types, constants and command structs for the sorted sparse matrix store
package ssms_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int INDEX_BITS = 10;
    localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS = 11;
    localparam int ENTRY_BITS = 2 * INDEX_BITS + 64 + 16;

    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_COUNT = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic signed [KEY_BITS-1:0] row_index;
        logic signed [KEY_BITS-1:0] col_index;
        logic [63:0] elem_value;
        logic signed [15:0] tag_value;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [63:0] found_value;
        logic signed [15:0] found_tag;
        logic [6:0] entry_count;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;     // capture input item, reset walk pointer
        logic rd_en;         // read entry at rd_addr
        logic [ADDR_BITS-1:0] rd_addr;
        logic wr_en;
        logic wr_key;        // write item key/value (else shift word)
        logic [ADDR_BITS-1:0] wr_addr;
        logic count_inc;
        logic clear_all;
        logic bump_largest;
        logic [1:0] res_status;
        logic res_hit;
        logic res_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic set_bad;
        logic get_range;
        logic ahead;         // read entry orders ahead of key
        logic key_equal;     // exact coordinate match for set
        logic get_match;     // wildcard-aware match for get
        logic [COUNT_BITS-1:0] count;
    } stat_t;
endpackage

// File: design/sorted_sparse_matrix_store.sv
// top level of the sorted coordinate-list sparse matrix store
//
// channel   | direction | tdata fields (low bit up)                      | tuser
// s_axis    | in        | row_index, col_index, elem_value, tag_value    | op
// m_axis    | out       | found_value, found_tag, entry_count (pad to 88)| status
// cfg       | in        | row_major_order                                 | -
//
// one item at a time; clear and count answer without a walk, a get walks
// the entries in order from the first, and a set walks the same way, then
// shifts each entry from the insert point up by one place before it writes
// the new entry (on a match it overwrites that entry in place instead)
// the walk and shift share the single read and write port of the entry memory
// reset clears count and largest indices; entry memory is not cleared
// a result waits in its register until taken; no new item is taken meanwhile
module sorted_sparse_matrix_store (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // row_index[10:0], col_index, elem_value, tag_value
    input  logic [1:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,  // found_value[63:0], found_tag, entry_count
    output logic [1:0]   m_axis_tuser,  // status
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);
    import ssms_pkg::*;

    item_t   item;
    result_t result;
    cmd_t    cmd;
    stat_t   stat;
    logic    row_major_order_reg;

    // configuration register; the user writes it only while idle, the block itself does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_major_order_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            row_major_order_reg <= cfg_wr_data;
        end
    end

    assign item.op = s_axis_tuser;
    assign item.row_index = s_axis_tdata[10:0];
    assign item.col_index = s_axis_tdata[21:11];
    assign item.elem_value = s_axis_tdata[85:22];
    assign item.tag_value = s_axis_tdata[101:86];

    ssms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ssms_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_in         (item),
        .row_major_order (row_major_order_reg),
        .cmd             (cmd),
        .stat            (stat),
        .result          (result)
    );

    // result transfer fields
    assign m_axis_tdata = {1'b0, result.entry_count, result.found_tag, result.found_value};
    assign m_axis_tuser = result.status;
endmodule

// File: design/ssms_ram.sv
// generic single-port-write ram with registered read
module ssms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: design/ssms_datapath.sv
// datapath: item register, entry memory, compare logic and result register
module ssms_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  ssms_pkg::item_t     item_in,
    input  logic                row_major_order,
    input  ssms_pkg::cmd_t      cmd,
    output ssms_pkg::stat_t     stat,
    output ssms_pkg::result_t   result
);
    import ssms_pkg::*;

    item_t item_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [INDEX_BITS-1:0] largest_row_reg, largest_col_reg;
    logic [ENTRY_BITS-1:0] rd_data, wr_data;
    logic [INDEX_BITS-1:0] er, ec;
    logic signed [KEY_BITS:0] ers, ecs, kr, kc;
    logic rw, cw;
    logic [INDEX_BITS-1:0] kr_u, kc_u;

    ssms_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    assign kr_u = item_reg.row_index[INDEX_BITS-1:0];
    assign kc_u = item_reg.col_index[INDEX_BITS-1:0];
    // shift moves the word just read; a new or updated entry writes the item
    assign wr_data = cmd.wr_key ? {kr_u, kc_u, item_reg.elem_value, item_reg.tag_value}
                                : rd_data;
    assign er = rd_data[ENTRY_BITS-1 -: INDEX_BITS];
    assign ec = rd_data[ENTRY_BITS-INDEX_BITS-1 -: INDEX_BITS];
    assign ers = $signed({2'b00, er});
    assign ecs = $signed({2'b00, ec});
    assign kr = {item_reg.row_index[KEY_BITS-1], item_reg.row_index};
    assign kc = {item_reg.col_index[KEY_BITS-1], item_reg.col_index};
    assign rw = (item_reg.row_index == -KEY_BITS'(1));
    assign cw = (item_reg.col_index == -KEY_BITS'(1));

    always_comb begin
        stat.op = item_reg.op;
        stat.count = count_reg;
        stat.set_bad = item_reg.row_index[KEY_BITS-1] || item_reg.col_index[KEY_BITS-1];
        stat.get_range = (kr > $signed({2'b00, largest_row_reg}))
                      || (kc > $signed({2'b00, largest_col_reg}));
        if (row_major_order) begin
            stat.ahead = (!rw && ers < kr) || (!cw && ers == kr && ecs < kc);
        end else begin
            stat.ahead = (!cw && ecs < kc) || (ecs == kc && !rw && ers < kr);
        end
        stat.key_equal = (ers == kr) && (ecs == kc);
        stat.get_match = (ers == kr || rw) && (ecs == kc || cw);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= item_in;
        end
        if (cmd.res_load) begin
            result.status <= cmd.res_status;
            result.found_value <= cmd.res_hit ? rd_data[79:16] : 64'd0;
            result.found_tag <= cmd.res_hit ? rd_data[15:0] : 16'sd0;
            result.entry_count <= 7'((cmd.count_inc ? count_reg + 1'b1
                                     : (cmd.clear_all ? '0 : count_reg)));
        end
        if (!aresetn) begin
            count_reg <= '0;
            largest_row_reg <= '0;
            largest_col_reg <= '0;
        end else begin
            if (cmd.clear_all) begin
                count_reg <= '0;
                largest_row_reg <= '0;
                largest_col_reg <= '0;
            end else begin
                if (cmd.count_inc) begin
                    count_reg <= count_reg + 1'b1;
                end
                if (cmd.bump_largest) begin
                    if (kr_u > largest_row_reg) largest_row_reg <= kr_u;
                    if (kc_u > largest_col_reg) largest_col_reg <= kc_u;
                end
            end
        end
    end
endmodule

// File: design/ssms_ctrl.sv
// controller: walk, shift and response sequencing
module ssms_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  ssms_pkg::stat_t  stat,
    output ssms_pkg::cmd_t   cmd
);
    import ssms_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [COUNT_BITS-1:0] ptr_reg, ptr_next;
    logic [COUNT_BITS-1:0] sh_reg, sh_next;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        sh_next = sh_reg;
        cmd = '0;
        cmd.rd_addr = ptr_reg[ADDR_BITS-1:0];
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    ptr_next = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.rd_addr = '0;
                cmd.res_load = 1'b1;
                cmd.res_status = ST_OK;
                case (stat.op)
                    OP_CLEAR: begin
                        cmd.clear_all = 1'b1;
                        state_next = S_OUT;
                    end
                    OP_COUNT: state_next = S_OUT;
                    OP_SET: begin
                        if (stat.set_bad) begin
                            cmd.res_status = ST_RANGE;
                            state_next = S_OUT;
                        end else begin
                            cmd.res_load = 1'b0;
                            state_next = S_WALK;
                        end
                    end
                    default: begin
                        if (stat.get_range) begin
                            cmd.res_status = ST_RANGE;
                            state_next = S_OUT;
                        end else begin
                            cmd.res_load = 1'b0;
                            state_next = S_WALK;
                        end
                    end
                endcase
            end
            S_WALK: begin
                // read entry ptr, evaluated next cycle
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (ptr_reg < stat.count && stat.ahead) begin
                    ptr_next = ptr_reg + 1'b1;
                    state_next = S_WALK;
                end else if (stat.op == OP_GET) begin
                    cmd.res_load = 1'b1;
                    if (ptr_reg < stat.count && stat.get_match) begin
                        cmd.res_hit = 1'b1;
                        cmd.res_status = ST_OK;
                    end else begin
                        cmd.res_status = ST_ABSENT;
                    end
                    state_next = S_OUT;
                end else if (ptr_reg < stat.count && stat.key_equal) begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_key = 1'b1;
                    cmd.wr_addr = ptr_reg[ADDR_BITS-1:0];
                    cmd.bump_largest = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next = S_OUT;
                end else if (stat.count >= COUNT_BITS'(TABLE_DEPTH)) begin
                    cmd.res_load = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next = S_OUT;
                end else begin
                    sh_next = stat.count;
                    cmd.rd_addr = ADDR_BITS'(stat.count - 1'b1);
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // rd_data holds entry sh-1; move it up, then fetch the next one
                if (sh_reg > ptr_reg) begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = sh_reg[ADDR_BITS-1:0];
                    cmd.rd_addr = ADDR_BITS'(sh_reg - 2'd2);
                    sh_next = sh_reg - 1'b1;
                end else begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_key = 1'b1;
                    cmd.wr_addr = ptr_reg[ADDR_BITS-1:0];
                    cmd.count_inc = 1'b1;
                    cmd.bump_largest = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ptr_reg <= '0;
            sh_reg <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            sh_reg <= sh_next;
        end
    end
endmodule
